[rtl/core/idalr_pkg.sv]
// Shared types, codes and sizing constants for the lowest-reuse ID allocator.
// Used by idalr_ctrl, idalr_dp and id_allocator_lowest_reuse_core.
`timescale 1ns / 1ps
`default_nettype none

package idalr_pkg;

  // Field widths and ID space
  localparam int ID_W      = 8;
  localparam int STATUS_W  = 2;
  localparam int OP_W      = 2;
  localparam int NUM_IDS   = 256;
  localparam int IDX_W     = $clog2(NUM_IDS);
  localparam int NF_W      = IDX_W + 1;

  // Freed-map search splits the map into groups of GRP_W bits
  localparam int GRP_W     = 16;
  localparam int NUM_GRP   = NUM_IDS / GRP_W;
  localparam int BIT_IDX_W = $clog2(GRP_W);
  localparam int GRP_IDX_W = $clog2(NUM_GRP);

  typedef enum logic [OP_W-1:0] {
    OP_GET      = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_REGISTER = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_ACTIVE = 2'd1,
    ST_NONE_LEFT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GFLAG,
    S_GSEL,
    S_BSEL,
    S_EXEC
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic grp_flags;
    logic grp_sel;
    logic bit_sel;
    logic exec;
  } ctrl_cmd_t;

  // Index of the lowest set bit of a group word
  function automatic logic [BIT_IDX_W-1:0] lowest_bit(input logic [GRP_W-1:0] word);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int k = GRP_W - 1; k >= 0; k--) begin
      if (word[k]) idx = BIT_IDX_W'(k);
    end
    return idx;
  endfunction

  // Index of the lowest set group flag
  function automatic logic [GRP_IDX_W-1:0] lowest_grp(input logic [NUM_GRP-1:0] flags);
    logic [GRP_IDX_W-1:0] idx;
    idx = '0;
    for (int k = NUM_GRP - 1; k >= 0; k--) begin
      if (flags[k]) idx = GRP_IDX_W'(k);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[rtl/core/idalr_ctrl.sv]
// Controller state machine of the ID allocator: sequences the freed-map
// search for a get and the single execute step. Depends on idalr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idalr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [1:0]         in_op,
  output logic                    busy,
  output idalr_pkg::ctrl_cmd_t    cmd
);
  import idalr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (op_t'(in_op) == OP_GET) state_nxt = S_GFLAG;
          else                        state_nxt = S_EXEC;
        end
      end
      S_GFLAG: begin
        cmd.grp_flags = 1'b1;
        state_nxt     = S_GSEL;
      end
      S_GSEL: begin
        cmd.grp_sel = 1'b1;
        state_nxt   = S_BSEL;
      end
      S_BSEL: begin
        cmd.bit_sel = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/idalr_dp.sv]
// Datapath of the ID allocator: active and freed maps, next-fresh counter,
// staged lowest-freed search and result registers. Depends on idalr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idalr_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire idalr_pkg::ctrl_cmd_t        cmd,
  input  wire logic [idalr_pkg::OP_W-1:0]  in_op,
  input  wire logic [idalr_pkg::ID_W-1:0]  in_id,
  input  wire logic                        cfg_wr_en,
  input  wire logic [idalr_pkg::ID_W-1:0]  cfg_wr_data,
  output logic                             out_valid,
  output logic [idalr_pkg::ID_W-1:0]       out_id_out,
  output logic [idalr_pkg::STATUS_W-1:0]   out_status
);
  import idalr_pkg::*;

  // Configuration and item registers
  logic [ID_W-1:0]      start_id_r;
  op_t                  op_r;
  logic [ID_W-1:0]      id_r;

  // Allocation state
  logic [NUM_IDS-1:0]   active_r, active_nxt;
  logic [NUM_IDS-1:0]   freed_r, freed_nxt;
  logic [NF_W-1:0]      nf_r, nf_nxt;

  // Search pipeline
  logic [NUM_GRP-1:0]   grp_any_r;
  logic [GRP_IDX_W-1:0] grp_idx_r;
  logic                 found_r;
  logic [IDX_W-1:0]     found_idx_r;
  logic [GRP_W-1:0]     grp_word;

  // Results
  logic                 out_valid_r;
  logic [ID_W-1:0]      id_out_r, id_out_nxt;
  status_t              status_r, status_nxt;

  logic [NF_W-1:0]      id_ext;
  logic                 id_in_space;

  assign id_ext      = {1'b0, id_r};
  assign id_in_space = id_ext < NF_W'(NUM_IDS);
  assign grp_word    = freed_r[grp_idx_r*GRP_W +: GRP_W];

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_id_r <= '0;
    end else if (cfg_wr_en) begin
      start_id_r <= cfg_wr_data;
    end
  end

  // Hold the item for the duration of the operation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(in_op);
      id_r <= in_id;
    end
  end

  // Search the freed map: group flags, lowest group, lowest bit in it
  always_ff @(posedge clk) begin
    if (cmd.grp_flags) begin
      for (int g = 0; g < NUM_GRP; g++) begin
        grp_any_r[g] <= |freed_r[g*GRP_W +: GRP_W];
      end
    end
    if (cmd.grp_sel) begin
      grp_idx_r <= lowest_grp(grp_any_r);
      found_r   <= |grp_any_r;
    end
    if (cmd.bit_sel) begin
      found_idx_r <= {grp_idx_r, lowest_bit(grp_word)};
    end
  end

  // Execute the operation on the maps and the counter
  always_comb begin
    active_nxt = active_r;
    freed_nxt  = freed_r;
    nf_nxt     = nf_r;
    id_out_nxt = '0;
    status_nxt = ST_OK;
    unique case (op_r)
      OP_GET: begin
        if (found_r) begin
          freed_nxt[found_idx_r]  = 1'b0;
          active_nxt[found_idx_r] = 1'b1;
          id_out_nxt              = found_idx_r;
        end else if (nf_r < NF_W'(NUM_IDS)) begin
          active_nxt[nf_r[IDX_W-1:0]] = 1'b1;
          id_out_nxt                  = nf_r[IDX_W-1:0];
          nf_nxt                      = nf_r + NF_W'(1);
        end else begin
          status_nxt = ST_NONE_LEFT;
        end
      end
      OP_RELEASE: begin
        if (id_in_space && active_r[id_r]) begin
          active_nxt[id_r] = 1'b0;
          freed_nxt[id_r]  = 1'b1;
        end else begin
          status_nxt = ST_NOT_ACTIVE;
        end
      end
      OP_REGISTER: begin
        if (id_in_space && !active_r[id_r]) begin
          if (freed_r[id_r]) begin
            freed_nxt[id_r]  = 1'b0;
            active_nxt[id_r] = 1'b1;
          end else if (id_ext >= nf_r) begin
            active_nxt[id_r] = 1'b1;
            // free every ID skipped between next-fresh and the given ID
            for (int k = 0; k < NUM_IDS; k++) begin
              if (NF_W'(k) >= nf_r && NF_W'(k) < id_ext) freed_nxt[k] = 1'b1;
            end
            nf_nxt = id_ext + NF_W'(1);
          end
        end
      end
      OP_CLEAR: begin
        active_nxt = '0;
        freed_nxt  = '0;
        nf_nxt     = {1'b0, start_id_r};
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      freed_r     <= '0;
      nf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
      if (cmd.exec) begin
        active_r <= active_nxt;
        freed_r  <= freed_nxt;
        nf_r     <= nf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      id_out_r <= id_out_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_id_out = id_out_r;
  assign out_status = status_r;

endmodule

`default_nettype wire

[rtl/core/id_allocator_lowest_reuse_core.sv]
// Top level of the lowest-reuse ID allocator: controller plus datapath.
// Depends on idalr_pkg, idalr_ctrl and idalr_dp.
//
// An item (in_op, in_id) is taken at a rising edge with start high and busy
// low. Its one result appears on out_id_out and out_status, marked by
// out_valid for exactly one cycle; the receiver cannot stall it. A get runs
// the three-stage search for the lowest freed ID (group flags, lowest group,
// lowest bit in that group) and then one execute step; release, register and
// clear go straight to the execute step. busy stays high until the result
// cycle, in which a new item may already be taken. The user must write
// start_id (cfg_wr_en, cfg_wr_data) only while the block is idle, which the
// block does not enforce; the next clear loads it into the fresh counter.
`timescale 1ns / 1ps
`default_nettype none

module id_allocator_lowest_reuse_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [idalr_pkg::OP_W-1:0]    in_op,
  input  wire logic [idalr_pkg::ID_W-1:0]    in_id,
  output logic                               out_valid,
  output logic [idalr_pkg::ID_W-1:0]         out_id_out,
  output logic [idalr_pkg::STATUS_W-1:0]     out_status,
  input  wire logic                          cfg_wr_en,
  input  wire logic [idalr_pkg::ID_W-1:0]    cfg_wr_data
);
  import idalr_pkg::*;

  ctrl_cmd_t cmd;

  // Sequence each operation
  idalr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Maps, counter, search and results
  idalr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_op       (in_op),
    .in_id       (in_id),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_id_out  (out_id_out),
    .out_status  (out_status)
  );

endmodule

`default_nettype wire
